### sv/pfe_pkg.sv
// pfe_pkg: shared types and constants for the packet format encoder
// no dependencies; used by the interfaces and every module of the block
package pfe_pkg;

    localparam int DIV_STEPS = 16;
    localparam int REM_W     = 4;

    localparam logic [31:0] PAT_1010 = 32'hAAAA_AAAA;
    localparam logic [31:0] PAT_0101 = 32'h5555_5555;

    localparam logic [31:0] POLY_8_ZERO  = 32'h0000_0000;
    localparam logic [31:0] POLY_8_A     = 32'h0000_0007;
    localparam logic [31:0] POLY_16_A    = 32'h0000_8005;
    localparam logic [31:0] POLY_16_B    = 32'h0000_1021;
    localparam logic [31:0] POLY_16_C    = 32'h0000_3d65;
    localparam logic [31:0] POLY_24_A    = 32'h0000_065b;
    localparam logic [31:0] POLY_32_A    = 32'h8141_41ab;
    localparam logic [31:0] POLY_32_B    = 32'h04c1_1db7;

    localparam logic [4:0] SYNC_CODE_MAX = 5'd31;
    localparam logic [3:0] PRE_CODE_MAX  = 4'd15;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SYNC = 3'd1,
        ST_BAD_PRE  = 3'd2,
        ST_BAD_PAT  = 3'd3,
        ST_BAD_POLY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CW_8  = 2'd0,
        CW_16 = 2'd1,
        CW_24 = 2'd2,
        CW_32 = 2'd3
    } crc_width_t;

    typedef struct packed {
        logic [4:0]  sync_len_code;
        logic [31:0] sync_value;
        logic [3:0]  preamble_len_code;
        logic [31:0] preamble_pattern;
        logic [15:0] tx_preamble_bits;
        logic [31:0] crc_poly;
        logic [31:0] crc_preset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  sync_bits;
        logic [31:0] sync_word;
        logic [3:0]  preamble_bits;
        logic [14:0] preamble_base;
        logic [15:0] preamble_repeats;
        logic [1:0]  crc_width;
        logic [31:0] crc_poly_reversed;
        logic [31:0] crc_init;
    } rsp_t;

    typedef struct packed {
        status_t          status;
        logic [4:0]       sync_bits;
        logic [31:0]      sync_word;
        logic [3:0]       preamble_bits;
        logic [14:0]      preamble_base;
        crc_width_t       crc_width;
        logic [31:0]      crc_poly_reversed;
        logic [31:0]      crc_init;
        logic [REM_W-1:0] divisor;
        logic [REM_W-1:0] rem;
        logic [15:0]      quo;
    } cell_t;

endpackage

### sv/pfe_ifs.sv
// pfe_ifs: valid/ready channels for request and response beats
// depends on pfe_pkg for the payload types
interface pfe_req_if;
    logic          valid;
    logic          ready;
    pfe_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pfe_rsp_if;
    logic          valid;
    logic          ready;
    pfe_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/pfe_check.sv
// pfe_check: request checks and field encoding ahead of the divider chain
// depends on pfe_pkg
module pfe_check (
    input  pfe_pkg::req_t  req,
    output pfe_pkg::cell_t head
);

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = v[31-i];
        end
        return r;
    endfunction

    logic [4:0]           unit;
    logic [14:0]          mask;
    logic [14:0]          pre;
    logic                 sync_ok;
    logic                 pre_ok;
    logic                 pat_ok;
    logic                 poly_ok;
    pfe_pkg::crc_width_t  width;
    logic [31:0]          poly_rev;
    logic [31:0]          poly_out;
    logic [4:0]           sync_shift;
    pfe_pkg::status_t     status;

    always_comb
    begin
        unit       = {1'b0, req.preamble_len_code} + 5'd1;
        mask       = ~(15'h7FFF << unit);
        pre        = req.preamble_pattern[14:0] & mask;
        sync_ok    = (req.sync_len_code[1:0] == 2'b11)
                     && (req.sync_len_code != pfe_pkg::SYNC_CODE_MAX);
        pre_ok     = (req.preamble_len_code != pfe_pkg::PRE_CODE_MAX);
        pat_ok     = (pre == (pfe_pkg::PAT_1010[14:0] & mask))
                     || (pre == (pfe_pkg::PAT_0101[14:0] & mask));
        sync_shift = pfe_pkg::SYNC_CODE_MAX - req.sync_len_code;
        poly_rev   = rev32(req.crc_poly);

        poly_ok = 1'b1;
        unique case (req.crc_poly)
            pfe_pkg::POLY_8_ZERO, pfe_pkg::POLY_8_A:
                width = pfe_pkg::CW_8;
            pfe_pkg::POLY_16_A, pfe_pkg::POLY_16_B, pfe_pkg::POLY_16_C:
                width = pfe_pkg::CW_16;
            pfe_pkg::POLY_24_A:
                width = pfe_pkg::CW_24;
            pfe_pkg::POLY_32_A, pfe_pkg::POLY_32_B:
                width = pfe_pkg::CW_32;
            default:
            begin
                width   = pfe_pkg::CW_8;
                poly_ok = 1'b0;
            end
        endcase

        unique case (width)
            pfe_pkg::CW_8:  poly_out = poly_rev >> 24;
            pfe_pkg::CW_16: poly_out = poly_rev >> 16;
            pfe_pkg::CW_24: poly_out = poly_rev >> 8;
            pfe_pkg::CW_32: poly_out = poly_rev;
            default:        poly_out = poly_rev;
        endcase

        priority if (!sync_ok)
            status = pfe_pkg::ST_BAD_SYNC;
        else if (!pre_ok)
            status = pfe_pkg::ST_BAD_PRE;
        else if (!pat_ok)
            status = pfe_pkg::ST_BAD_PAT;
        else if (!poly_ok)
            status = pfe_pkg::ST_BAD_POLY;
        else
            status = pfe_pkg::ST_OK;

        head        = '0;
        head.status = status;
        head.divisor = 4'd1;
        head.crc_width = pfe_pkg::CW_8;
        if (status == pfe_pkg::ST_OK)
        begin
            head.sync_bits         = req.sync_len_code;
            head.sync_word         = rev32(req.sync_value) >> sync_shift;
            head.preamble_bits     = req.preamble_len_code;
            head.preamble_base     = pre;
            head.crc_width         = width;
            head.crc_poly_reversed = poly_out;
            head.crc_init          = req.crc_preset;
            head.divisor           = unit[pfe_pkg::REM_W-1:0];
            head.quo               = req.tx_preamble_bits;
        end
    end

endmodule

### sv/pfe_div_cell.sv
// pfe_div_cell: one restoring-division step with its own beat register
// depends on pfe_pkg; chained to form the repeat-count divider
module pfe_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pfe_pkg::cell_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pfe_pkg::cell_t out_data
);

    logic                   valid_reg;
    pfe_pkg::cell_t         data_reg;
    pfe_pkg::cell_t         data_next;
    logic [pfe_pkg::REM_W:0] trial;
    logic [pfe_pkg::REM_W:0] diff;
    logic                   take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        trial     = {in_data.rem, in_data.quo[15]};
        diff      = trial - {1'b0, in_data.divisor};
        take      = (trial >= {1'b0, in_data.divisor});
        data_next = in_data;
        data_next.rem = take ? diff[pfe_pkg::REM_W-1:0] : trial[pfe_pkg::REM_W-1:0];
        data_next.quo = {in_data.quo[14:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem < data_reg.divisor))
        else $error("remainder not below divisor");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.divisor != '0))
        else $error("zero divisor in chain");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.status != pfe_pkg::ST_OK)
        |-> (data_reg.quo == '0 && data_reg.rem == '0))
        else $error("error beat carries division data");
`endif

endmodule

### sv/packet_format_encoder_core.sv
// packet_format_encoder_core: top level of the packet format encoder
// depends on pfe_pkg, pfe_ifs, pfe_check and pfe_div_cell
//
//   channel  dir  payload  handshake
//   req      in   req_t    valid/ready, beat taken when both high
//   rsp      out  rsp_t    valid/ready, beat taken when both high
//
// one beat per cycle sustained while rsp.ready stays high; each quotient bit of
// the repeat-count division is one step, held in its own cell of the chain
// reset clears only the cell valid bits
// a stalled rsp beat holds in the last cell; earlier cells keep filling and
// req.ready drops only once all 16 cells hold beats
module packet_format_encoder_core (
    input logic        clk,
    input logic        rst_n,
    pfe_req_if.sink    req,
    pfe_rsp_if.source  rsp
);

    logic           cell_valid [pfe_pkg::DIV_STEPS+1];
    logic           cell_ready [pfe_pkg::DIV_STEPS+1];
    pfe_pkg::cell_t cell_data  [pfe_pkg::DIV_STEPS+1];

    pfe_check u_check (
        .req  (req.data),
        .head (cell_data[0])
    );

    assign cell_valid[0] = req.valid;
    assign req.ready     = cell_ready[0];

    for (genvar g = 0; g < pfe_pkg::DIV_STEPS; g++)
    begin : g_cell
        pfe_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[g]),
            .in_ready  (cell_ready[g]),
            .in_data   (cell_data[g]),
            .out_valid (cell_valid[g+1]),
            .out_ready (cell_ready[g+1]),
            .out_data  (cell_data[g+1])
        );
    end

    assign cell_ready[pfe_pkg::DIV_STEPS] = rsp.ready;
    assign rsp.valid = cell_valid[pfe_pkg::DIV_STEPS];

    always_comb
    begin
        rsp.data.status            = cell_data[pfe_pkg::DIV_STEPS].status;
        rsp.data.sync_bits         = cell_data[pfe_pkg::DIV_STEPS].sync_bits;
        rsp.data.sync_word         = cell_data[pfe_pkg::DIV_STEPS].sync_word;
        rsp.data.preamble_bits     = cell_data[pfe_pkg::DIV_STEPS].preamble_bits;
        rsp.data.preamble_base     = cell_data[pfe_pkg::DIV_STEPS].preamble_base;
        rsp.data.preamble_repeats  = cell_data[pfe_pkg::DIV_STEPS].quo;
        rsp.data.crc_width         = cell_data[pfe_pkg::DIV_STEPS].crc_width;
        rsp.data.crc_poly_reversed = cell_data[pfe_pkg::DIV_STEPS].crc_poly_reversed;
        rsp.data.crc_init          = cell_data[pfe_pkg::DIV_STEPS].crc_init;
    end

`ifndef NO_ASSERTIONS
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status != pfe_pkg::ST_OK)
        |-> (rsp.data.sync_bits == '0 && rsp.data.sync_word == '0
             && rsp.data.preamble_bits == '0 && rsp.data.preamble_base == '0
             && rsp.data.preamble_repeats == '0 && rsp.data.crc_width == '0
             && rsp.data.crc_poly_reversed == '0 && rsp.data.crc_init == '0))
        else $error("error beat with nonzero fields");
    a_ok_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == pfe_pkg::ST_OK)
        |-> (rsp.data.sync_bits[1:0] == 2'b11
             && rsp.data.sync_bits != pfe_pkg::SYNC_CODE_MAX
             && rsp.data.preamble_bits != pfe_pkg::PRE_CODE_MAX))
        else $error("ok beat with rejected length code");
    a_ok_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == pfe_pkg::ST_OK
         && rsp.data.preamble_bits == '0)
        |-> (rsp.data.preamble_repeats
             == cell_data[pfe_pkg::DIV_STEPS].quo
             && cell_data[pfe_pkg::DIV_STEPS].rem == '0))
        else $error("unit divisor left a remainder");
`endif

endmodule

### sim/packet_format_encoder_core_tb.sv
`timescale 1ns / 1ps
// packet_format_encoder_core_tb: self-checking bench for the packet format encoder core
// depends on pfe_pkg, pfe_ifs and packet_format_encoder_core; predicts every response beat
// from its request and checks it field by field under random stalls on both channels
module packet_format_encoder_core_tb;
    import pfe_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 100;
    localparam int TAIL_ITEMS   = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pfe_req_if req_ch ();
    pfe_rsp_if rsp_ch ();

    packet_format_encoder_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [31:0] known_polys [8] = '{POLY_8_ZERO, POLY_8_A, POLY_16_A, POLY_16_B,
                                     POLY_16_C, POLY_24_A, POLY_32_A, POLY_32_B};

    req_t request_fifo[$];
    bit   drain_first[$];
    rsp_t expected_formats[$];

    int total_items = 0;
    int rsp_beats = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int sent_count = 0;
    int send_gap = 0;
    int send_gap_pct = 0;
    int take_gap = 0;
    int take_gap_pct = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic hold_active = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic rsp_t predict_format(input req_t r);
        rsp_t        res;
        logic [5:0]  sync_len;
        logic [4:0]  unit;
        logic [31:0] mask;
        logic [31:0] base;
        logic [31:0] sync_rev;
        logic [31:0] poly_rev;
        crc_width_t  cw;
        bit          poly_known;
        int          nbits;
        res = '0;
        sync_len = {1'b0, r.sync_len_code} + 6'd1;
        unit = {1'b0, r.preamble_len_code} + 5'd1;
        mask = (32'd1 << unit) - 32'd1;
        base = r.preamble_pattern & mask;
        poly_known = 1'b1;
        cw = CW_8;
        case (r.crc_poly)
            POLY_8_ZERO, POLY_8_A:           cw = CW_8;
            POLY_16_A, POLY_16_B, POLY_16_C: cw = CW_16;
            POLY_24_A:                       cw = CW_24;
            POLY_32_A, POLY_32_B:            cw = CW_32;
            default:                         poly_known = 1'b0;
        endcase
        if (sync_len[5] || sync_len[1:0] != 2'd0)
            res.status = ST_BAD_SYNC;
        else if (unit[4])
            res.status = ST_BAD_PRE;
        else if (base != (PAT_1010 & mask) && base != (PAT_0101 & mask))
            res.status = ST_BAD_PAT;
        else if (!poly_known)
            res.status = ST_BAD_POLY;
        else
        begin
            for (int i = 0; i < 32; i++)
                sync_rev[31 - i] = r.sync_value[i];
            nbits = 8 * (int'(cw) + 1);
            poly_rev = '0;
            for (int i = 0; i < nbits; i++)
                poly_rev[nbits - 1 - i] = r.crc_poly[i];
            res.status = ST_OK;
            res.sync_bits = r.sync_len_code;
            res.sync_word = sync_rev >> (32 - sync_len);
            res.preamble_bits = r.preamble_len_code;
            res.preamble_base = base[14:0];
            res.preamble_repeats = r.tx_preamble_bits / unit;
            res.crc_width = cw;
            res.crc_poly_reversed = poly_rev;
            res.crc_init = r.crc_preset;
        end
        return res;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 6;
            2:       return 20;
            default: return 45;
        endcase
    endfunction

    task automatic add_format(input logic [4:0] slc, input logic [31:0] sval,
                              input logic [3:0] plc, input logic [31:0] pat,
                              input logic [15:0] tx, input logic [31:0] poly,
                              input logic [31:0] seed, input bit drain);
        req_t r;
        r.sync_len_code = slc;
        r.sync_value = sval;
        r.preamble_len_code = plc;
        r.preamble_pattern = pat;
        r.tx_preamble_bits = tx;
        r.crc_poly = poly;
        r.crc_preset = seed;
        request_fifo.push_back(r);
        drain_first.push_back(drain);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch in %s: got %0h, expected %0h", $time, field, got, want);
        error_count++;
    endtask

    task automatic compare_result(input rsp_t got, input rsp_t want);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.sync_bits !== want.sync_bits)
            report_mismatch("sync_bits", 32'(got.sync_bits), 32'(want.sync_bits));
        if (got.sync_word !== want.sync_word)
            report_mismatch("sync_word", got.sync_word, want.sync_word);
        if (got.preamble_bits !== want.preamble_bits)
            report_mismatch("preamble_bits", 32'(got.preamble_bits),
                            32'(want.preamble_bits));
        if (got.preamble_base !== want.preamble_base)
            report_mismatch("preamble_base", 32'(got.preamble_base),
                            32'(want.preamble_base));
        if (got.preamble_repeats !== want.preamble_repeats)
            report_mismatch("preamble_repeats", 32'(got.preamble_repeats),
                            32'(want.preamble_repeats));
        if (got.crc_width !== want.crc_width)
            report_mismatch("crc_width", 32'(got.crc_width), 32'(want.crc_width));
        if (got.crc_poly_reversed !== want.crc_poly_reversed)
            report_mismatch("crc_poly_reversed", got.crc_poly_reversed,
                            want.crc_poly_reversed);
        if (got.crc_init !== want.crc_init)
            report_mismatch("crc_init", got.crc_init, want.crc_init);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                sent_count++;
                if (sent_count % 50 == 0)
                    send_gap_pct = pick_idle_pct();
                if (!hold_active && sent_count < total_items - TAIL_ITEMS
                        && $urandom_range(99) < send_gap_pct)
                    send_gap = $urandom_range(14, 1);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_fifo.size() > 0
                        && !(drain_first[0] && sent_count != rsp_beats))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data <= request_fifo.pop_front();
                    void'(drain_first.pop_front());
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response ready, with one long hold-off to fill the pipe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_active <= 1'b0;
        end
        else
        begin
            if (!hold_done && rsp_beats >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(199) == 0)
                take_gap_pct = pick_idle_pct();
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_beats < total_items - TAIL_ITEMS
                    && $urandom_range(99) < take_gap_pct)
            begin
                take_gap = $urandom_range(14, 1) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
            hold_active <= (hold_left > 0);
        end
    end

    // monitor: check response beats, then queue predictions for request beats
    always @(posedge clk)
    begin : monitor_beat
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_beats <= rsp_beats + 1;
                if (expected_formats.size() == 0)
                    report_mismatch("unexpected beat", 32'(rsp_ch.data.status), '0);
                else
                begin
                    want = expected_formats.pop_front();
                    compare_result(rsp_ch.data, want);
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_formats.push_back(predict_format(req_ch.data));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [4:0]  slc;
        logic [31:0] sval;
        logic [3:0]  plc;
        logic [31:0] pat;
        logic [15:0] tx;
        logic [31:0] poly;
        logic [31:0] seed;
        logic [31:0] unit_mask;

        // good formats over every polynomial and the length extremes
        add_format(5'd3, 32'hFFFF_FFFF, 4'd0, 32'h0, 16'h0, POLY_8_ZERO, 32'h0, 1'b0);
        add_format(5'd27, 32'h8000_0001, 4'd0, 32'h1, 16'hFFFF, POLY_8_A, 32'hFFFF_FFFF, 1'b0);
        add_format(5'd7, 32'hA5C3_0F01, 4'd14, PAT_1010, 16'hFFFF, POLY_16_A, 32'h1234_5678,
                   1'b0);
        add_format(5'd11, 32'h7E81_3C5A, 4'd14, PAT_0101, 16'd15, POLY_16_B, 32'hFFFF, 1'b0);
        add_format(5'd15, 32'h0000_FFFF, 4'd7, 32'hFFFF_FF55, 16'd1000, POLY_16_C, 32'h0, 1'b0);
        add_format(5'd19, 32'hDEAD_BEEF, 4'd3, 32'h0000_000A, 16'd7, POLY_24_A, 32'h00FF_FFFF,
                   1'b0);
        add_format(5'd23, 32'h1234_5678, 4'd1, 32'hFFFF_FFFE, 16'd1, POLY_32_A, 32'hFFFF_FFFF,
                   1'b0);
        add_format(5'd27, 32'hFFFF_FFFF, 4'd4, 32'h15, 16'd65535, POLY_32_B, 32'hA5A5_5A5A, 1'b0);
        add_format(5'd3, 32'h0000_0001, 4'd9, PAT_0101 | 32'hFFFF_FC00, 16'hFFFF, POLY_8_A,
                   32'h0, 1'b0);
        add_format(5'd27, 32'h0F0F_0F0F, 4'd14, PAT_1010, 16'd14, POLY_16_A, 32'h8000_0000, 1'b0);

        // each error, and the first failing check taking priority
        add_format(SYNC_CODE_MAX, 32'hFFFF_FFFF, 4'd3, PAT_1010, 16'd8, POLY_8_A, 32'h1, 1'b0);
        add_format(5'd0, 32'hFFFF_FFFF, 4'd3, PAT_1010, 16'd8, POLY_8_A, 32'h1, 1'b0);
        add_format(5'd4, 32'hFFFF_FFFF, 4'd3, PAT_1010, 16'd8, POLY_8_A, 32'h1, 1'b0);
        add_format(5'd2, 32'hFFFF_FFFF, PRE_CODE_MAX, 32'h3, 16'd8, 32'hFFFF_FFFF, 32'h1, 1'b0);
        add_format(5'd3, 32'hFFFF_FFFF, PRE_CODE_MAX, PAT_1010, 16'd8, POLY_16_B, 32'h1, 1'b0);
        add_format(5'd7, 32'hFFFF_FFFF, PRE_CODE_MAX, 32'h0, 16'd8, 32'hFFFF_FFFF, 32'h1, 1'b0);
        add_format(5'd7, 32'hFFFF_FFFF, 4'd3, 32'h3, 16'd8, POLY_24_A, 32'h1, 1'b0);
        add_format(5'd7, 32'hFFFF_FFFF, 4'd3, 32'h3, 16'd8, 32'h0000_0008, 32'h1, 1'b0);
        add_format(5'd7, 32'hFFFF_FFFF, 4'd3, PAT_1010, 16'd8, 32'h0000_0008, 32'h1, 1'b0);
        add_format(5'd7, 32'hFFFF_FFFF, 4'd3, PAT_0101, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   1'b0);

        // mostly well-formed requests, some broken in one check, some noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            slc = 5'(4 * $urandom_range(7, 1) - 1);
            sval = $urandom();
            plc = 4'($urandom_range(14));
            unit_mask = (32'd1 << (int'(plc) + 1)) - 32'd1;
            pat = (($urandom_range(1) ? PAT_1010 : PAT_0101) & unit_mask)
                  | ($urandom() & ~unit_mask);
            tx = 16'($urandom());
            poly = known_polys[$urandom_range(7)];
            seed = $urandom();
            if ($urandom_range(99) < 25)
            begin
                case ($urandom_range(4))
                    0:
                    begin
                        slc = 5'($urandom());
                        plc = 4'($urandom());
                        pat = $urandom();
                        poly = $urandom();
                    end
                    1: slc = ($urandom_range(7) == 0) ? SYNC_CODE_MAX
                             : 5'(4 * $urandom_range(7) + $urandom_range(2));
                    2: plc = PRE_CODE_MAX;
                    3: pat = pat ^ (32'd1 << $urandom_range(int'(plc)));
                    default: poly = $urandom();
                endcase
            end
            add_format(slc, sval, plc, pat, tx, poly, seed, i == 0 || i == 250);
        end
        total_items = request_fifo.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (rsp_beats < total_items)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_formats.size() != 0)
            report_mismatch("results never came", 32'(expected_formats.size()), '0);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### sim.f
sv/pfe_pkg.sv
sv/pfe_ifs.sv
sv/pfe_check.sv
sv/pfe_div_cell.sv
sv/packet_format_encoder_core.sv
sim/packet_format_encoder_core_tb.sv
